// ----- hdl/trp_pkg.sv -----
`default_nettype none
package trp_pkg;

	localparam int OP_W        = 2;
	localparam int IDX_W       = 6;
	localparam int COORD_W     = 21;
	localparam int CNT_OUT_W   = 7;
	localparam int CNT_OUT_MAX = 127;

	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_POLL = 2'd1;
	localparam logic [OP_W-1:0] OP_REQ  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_lo;
		logic signed [COORD_W-1:0] y_lo;
		logic signed [COORD_W-1:0] x_hi;
		logic signed [COORD_W-1:0] y_hi;
		logic [COORD_W-1:0]        span_x;
		logic [COORD_W-1:0]        span_y;
	} bound_t;

	typedef struct packed {
		logic en;
		logic rq;
	} flags_t;

	typedef struct packed {
		logic latch;
		logic rd_en;
		logic use_idx;
		logic poll_en;
		logic clr_we;
		logic set_wr;
		logic req_wr;
		logic res_load;
	} ctl_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            idx_ok;
		logic            pipe_busy;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/trp_cmd_if.sv -----
`default_nettype none
interface trp_cmd_if;
	import trp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [IDX_W-1:0]          tile_index;
	logic signed [COORD_W-1:0] x_start;
	logic signed [COORD_W-1:0] y_start;
	logic signed [COORD_W-1:0] x_end;
	logic signed [COORD_W-1:0] y_end;
	logic signed [COORD_W-1:0] view_x;
	logic signed [COORD_W-1:0] view_y;

	modport source (
		output valid, operation, tile_index, x_start, y_start, x_end, y_end, view_x, view_y,
		input  ready
	);

	modport sink (
		input  valid, operation, tile_index, x_start, y_start, x_end, y_end, view_x, view_y,
		output ready
	);

endinterface
`default_nettype wire

// ----- hdl/trp_rsp_if.sv -----
`default_nettype none
interface trp_rsp_if;
	import trp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 any_requested;
	logic                 granted;
	logic [CNT_OUT_W-1:0] enabled_count;

	modport source (
		output valid, any_requested, granted, enabled_count,
		input  ready
	);

	modport sink (
		input  valid, any_requested, granted, enabled_count,
		output ready
	);

endinterface
`default_nettype wire

// ----- hdl/tile_residency_policy_top.sv -----
`default_nettype none
// Tile residency policy. Each request on cmd carries one operation and yields exactly one
// response on rsp. Set tile, request tile and no-op finish without a scan, and so does poll
// while overview scanning is set; otherwise poll visits one tile entry per cycle through
// the single read port of the tile memories, followed by a four-stage distance pipeline
// that writes the flags back. A new request is accepted once the previous response has
// been loaded into the output register. After reset a clearing pass over every entry
// zeroes the tile memories; no request is accepted during it, while configuration writes
// are taken at any time. The enabled count is kept as a running counter, so request needs
// no walk over the table.
module tile_residency_policy_top #(
	parameter int TILE_COUNT   = 64,
	parameter int ACTIVE_LIMIT = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	trp_cmd_if.sink    cmd,
	trp_rsp_if.source  rsp,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);
	import trp_pkg::*;

	ctl_t                          ctl;
	sts_t                          sts;
	logic [$clog2(TILE_COUNT)-1:0] addr;

	trp_ctrl #(
		.TILE_COUNT (TILE_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.addr      (addr),
		.sts       (sts)
	);

	trp_dp #(
		.TILE_COUNT   (TILE_COUNT),
		.ACTIVE_LIMIT (ACTIVE_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.addr          (addr),
		.sts           (sts),
		.operation     (cmd.operation),
		.tile_index    (cmd.tile_index),
		.x_start       (cmd.x_start),
		.y_start       (cmd.y_start),
		.x_end         (cmd.x_end),
		.y_end         (cmd.y_end),
		.view_x        (cmd.view_x),
		.view_y        (cmd.view_y),
		.any_requested (rsp.any_requested),
		.granted       (rsp.granted),
		.enabled_count (rsp.enabled_count)
	);

endmodule
`default_nettype wire

// ----- hdl/trp_ram.sv -----
`default_nettype none
module trp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/trp_ctrl.sv -----
`default_nettype none
module trp_ctrl #(
	parameter int TILE_COUNT = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_wdata,
	output trp_pkg::ctl_t                      ctl,
	output logic [$clog2(TILE_COUNT)-1:0]      addr,
	input  wire trp_pkg::sts_t                 sts
);
	import trp_pkg::*;

	localparam int AW = $clog2(TILE_COUNT);

	localparam logic [2:0] S_CLEAR      = 3'd0;
	localparam logic [2:0] S_IDLE       = 3'd1;
	localparam logic [2:0] S_DECODE     = 3'd2;
	localparam logic [2:0] S_REQ_WB     = 3'd3;
	localparam logic [2:0] S_POLL_RD    = 3'd4;
	localparam logic [2:0] S_POLL_DRAIN = 3'd5;
	localparam logic [2:0] S_FINISH     = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] addr_q, addr_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic          ovs_q;
	logic          last;

	assign last = (addr_q == AW'(TILE_COUNT - 1));

	always_comb begin
		ctl         = '0;
		state_d     = state_q;
		addr_d      = addr_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		cmd_ready   = (state_q == S_IDLE);
		case (state_q)
			S_CLEAR: begin
				ctl.clr_we = 1'b1;
				addr_d     = addr_q + AW'(1);
				if (last) begin
					addr_d  = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				case (sts.op)
					OP_SET: begin
						ctl.use_idx = 1'b1;
						ctl.set_wr  = sts.idx_ok;
					end
					OP_POLL: begin
						if (!ovs_q) begin
							addr_d  = '0;
							state_d = S_POLL_RD;
						end
					end
					OP_REQ: begin
						if (sts.idx_ok) begin
							ctl.use_idx = 1'b1;
							ctl.rd_en   = 1'b1;
							state_d     = S_REQ_WB;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_REQ_WB: begin
				ctl.use_idx = 1'b1;
				ctl.req_wr  = 1'b1;
				state_d     = S_FINISH;
			end
			S_POLL_RD: begin
				ctl.rd_en   = 1'b1;
				ctl.poll_en = 1'b1;
				addr_d      = addr_q + AW'(1);
				if (last) begin
					addr_d  = '0;
					state_d = S_POLL_DRAIN;
				end
			end
			S_POLL_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					ctl.res_load = 1'b1;
					rsp_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			rsp_valid_q <= 1'b0;
			ovs_q       <= 1'b1;
		end else begin
			state_q     <= state_d;
			addr_q      <= addr_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_we) begin
				ovs_q <= cfg_wdata;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign addr      = addr_q;

endmodule
`default_nettype wire

// ----- hdl/trp_dp.sv -----
`default_nettype none
module trp_dp #(
	parameter int TILE_COUNT   = 64,
	parameter int ACTIVE_LIMIT = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire trp_pkg::ctl_t                       ctl,
	input  wire logic [$clog2(TILE_COUNT)-1:0]       addr,
	output trp_pkg::sts_t                            sts,
	input  wire logic [trp_pkg::OP_W-1:0]            operation,
	input  wire logic [trp_pkg::IDX_W-1:0]           tile_index,
	input  wire logic signed [trp_pkg::COORD_W-1:0]  x_start,
	input  wire logic signed [trp_pkg::COORD_W-1:0]  y_start,
	input  wire logic signed [trp_pkg::COORD_W-1:0]  x_end,
	input  wire logic signed [trp_pkg::COORD_W-1:0]  y_end,
	input  wire logic signed [trp_pkg::COORD_W-1:0]  view_x,
	input  wire logic signed [trp_pkg::COORD_W-1:0]  view_y,
	output logic                                     any_requested,
	output logic                                     granted,
	output logic [trp_pkg::CNT_OUT_W-1:0]            enabled_count
);
	import trp_pkg::*;

	localparam int AW    = $clog2(TILE_COUNT);
	localparam int CNT_W = $clog2(TILE_COUNT + 1);
	localparam int DW    = COORD_W + 1;
	localparam int MW    = COORD_W + 2;

	function automatic logic [DW-1:0] abs_d(input logic [DW-1:0] d);
		return d[DW-1] ? (~d + DW'(1)) : d;
	endfunction

	logic [OP_W-1:0]           op_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [COORD_W-1:0] xs_q, ys_q, xe_q, ye_q, vx_q, vy_q;
	logic                      acc_q, grant_q;
	logic [CNT_W-1:0]          count_q;
	logic                      any_res_q, grant_res_q;
	logic [CNT_OUT_W-1:0]      count_res_q;

	logic [AW-1:0] idx_addr, raddr;
	bound_t        bnd_rd, bnd_set, bnd_wdata;
	flags_t        flg_rd, flg_wdata;
	logic          bnd_we, flg_we;
	logic [AW-1:0] bnd_waddr, flg_waddr;

	// poll pipeline
	logic          valid_s0;
	logic [AW-1:0] addr_s0;

	logic                 valid_s1, zero_s1, en_s1;
	logic [AW-1:0]        addr_s1;
	logic [DW-1:0]        dx1_s1, dx2_s1, dy1_s1, dy2_s1;
	logic [COORD_W-1:0]   w_s1, h_s1;
	logic [MW-1:0]        w3_s1, h3_s1;

	logic                 valid_s2, zero_s2, en_s2;
	logic [AW-1:0]        addr_s2;
	logic [DW-1:0]        ax1_s2, ax2_s2, ay1_s2, ay2_s2;
	logic [COORD_W-1:0]   w_s2, h_s2;
	logic [MW-1:0]        w3_s2, h3_s2;

	logic                 valid_s3, zero_s3, en_s3;
	logic [AW-1:0]        addr_s3;
	logic [DW-1:0]        mnx_s3, mxx_s3, mny_s3, mxy_s3;
	logic [COORD_W-1:0]   w_s3, h_s3;
	logic [MW-1:0]        w3_s3, h3_s3;

	logic near, far, poll_en_new, poll_rq;
	logic req_grant, req_en_new;

	assign idx_addr = AW'(idx_q);
	assign raddr    = ctl.use_idx ? idx_addr : addr;

	assign sts.op        = op_q;
	assign sts.idx_ok    = (32'(idx_q) < TILE_COUNT);
	assign sts.pipe_busy = valid_s0 || valid_s1 || valid_s2 || valid_s3;

	always_comb begin
		bnd_set.x_lo   = xs_q;
		bnd_set.y_lo   = ys_q;
		bnd_set.x_hi   = xe_q;
		bnd_set.y_hi   = ye_q;
		bnd_set.span_x = $unsigned(xe_q - xs_q);
		bnd_set.span_y = $unsigned(ye_q - ys_q);
	end

	assign bnd_we    = ctl.clr_we || ctl.set_wr;
	assign bnd_waddr = ctl.clr_we ? addr : idx_addr;
	assign bnd_wdata = ctl.clr_we ? bound_t'('0) : bnd_set;

	trp_ram #(
		.WIDTH ($bits(bound_t)),
		.DEPTH (TILE_COUNT)
	) u_bnd_ram (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bnd_waddr),
		.wdata (bnd_wdata),
		.re    (ctl.rd_en),
		.raddr (raddr),
		.rdata (bnd_rd)
	);

	// request evaluation on the flag and bound words read in the previous cycle
	assign req_grant  = flg_rd.rq && (32'(count_q) < ACTIVE_LIMIT);
	assign req_en_new = req_grant ? ((bnd_rd.span_x != '0) && (bnd_rd.span_y != '0))
	                              : flg_rd.en;

	// poll decision at the end of the pipeline
	assign near = (({mnx_s3, 1'b0} < w3_s3) && (mny_s3 < {1'b0, h_s3}))
	           || (({mny_s3, 1'b0} < h3_s3) && (mnx_s3 < {1'b0, w_s3}));
	assign far  = (mxx_s3 > {w_s3, 1'b0}) || (mxy_s3 > {h_s3, 1'b0});
	assign poll_en_new = en_s3 && !zero_s3 && (near || !far);
	assign poll_rq     = near && !en_s3;

	always_comb begin
		flg_we    = 1'b0;
		flg_waddr = addr_s3;
		flg_wdata = '0;
		if (ctl.clr_we) begin
			flg_we    = 1'b1;
			flg_waddr = addr;
		end else if (ctl.req_wr) begin
			flg_we       = 1'b1;
			flg_waddr    = idx_addr;
			flg_wdata.en = req_en_new;
			flg_wdata.rq = flg_rd.rq;
		end else if (valid_s3) begin
			flg_we       = 1'b1;
			flg_wdata.en = poll_en_new;
			flg_wdata.rq = poll_rq;
		end
	end

	trp_ram #(
		.WIDTH ($bits(flags_t)),
		.DEPTH (TILE_COUNT)
	) u_flg_ram (
		.clk   (clk),
		.we    (flg_we),
		.waddr (flg_waddr),
		.wdata (flg_wdata),
		.re    (ctl.rd_en),
		.raddr (raddr),
		.rdata (flg_rd)
	);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			op_q  <= operation;
			idx_q <= tile_index;
			xs_q  <= x_start;
			ys_q  <= y_start;
			xe_q  <= x_end;
			ye_q  <= y_end;
			vx_q  <= view_x;
			vy_q  <= view_y;
		end
		addr_s0 <= raddr;

		dx1_s1  <= {vx_q[COORD_W-1], vx_q} - {bnd_rd.x_lo[COORD_W-1], bnd_rd.x_lo};
		dx2_s1  <= {bnd_rd.x_hi[COORD_W-1], bnd_rd.x_hi} - {vx_q[COORD_W-1], vx_q};
		dy1_s1  <= {vy_q[COORD_W-1], vy_q} - {bnd_rd.y_lo[COORD_W-1], bnd_rd.y_lo};
		dy2_s1  <= {bnd_rd.y_hi[COORD_W-1], bnd_rd.y_hi} - {vy_q[COORD_W-1], vy_q};
		w_s1    <= bnd_rd.span_x;
		h_s1    <= bnd_rd.span_y;
		w3_s1   <= {2'b00, bnd_rd.span_x} + {1'b0, bnd_rd.span_x, 1'b0};
		h3_s1   <= {2'b00, bnd_rd.span_y} + {1'b0, bnd_rd.span_y, 1'b0};
		zero_s1 <= (bnd_rd.span_x == '0) || (bnd_rd.span_y == '0);
		en_s1   <= flg_rd.en;
		addr_s1 <= addr_s0;

		ax1_s2  <= abs_d(dx1_s1);
		ax2_s2  <= abs_d(dx2_s1);
		ay1_s2  <= abs_d(dy1_s1);
		ay2_s2  <= abs_d(dy2_s1);
		w_s2    <= w_s1;
		h_s2    <= h_s1;
		w3_s2   <= w3_s1;
		h3_s2   <= h3_s1;
		zero_s2 <= zero_s1;
		en_s2   <= en_s1;
		addr_s2 <= addr_s1;

		mnx_s3  <= (ax1_s2 < ax2_s2) ? ax1_s2 : ax2_s2;
		mxx_s3  <= (ax1_s2 > ax2_s2) ? ax1_s2 : ax2_s2;
		mny_s3  <= (ay1_s2 < ay2_s2) ? ay1_s2 : ay2_s2;
		mxy_s3  <= (ay1_s2 > ay2_s2) ? ay1_s2 : ay2_s2;
		w_s3    <= w_s2;
		h_s3    <= h_s2;
		w3_s3   <= w3_s2;
		h3_s3   <= h3_s2;
		zero_s3 <= zero_s2;
		en_s3   <= en_s2;
		addr_s3 <= addr_s2;

		if (ctl.res_load) begin
			any_res_q   <= acc_q;
			grant_res_q <= grant_q;
			count_res_q <= (32'(count_q) > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX)
			                                            : CNT_OUT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			count_q  <= '0;
			acc_q    <= 1'b0;
			grant_q  <= 1'b0;
		end else begin
			valid_s0 <= ctl.rd_en && ctl.poll_en;
			valid_s1 <= valid_s0;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (ctl.latch) begin
				acc_q   <= 1'b0;
				grant_q <= 1'b0;
			end else if (ctl.req_wr) begin
				grant_q <= req_grant;
				if (!flg_rd.en && req_en_new) begin
					count_q <= count_q + CNT_W'(1);
				end else if (flg_rd.en && !req_en_new) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (valid_s3) begin
				if (poll_rq) begin
					acc_q <= 1'b1;
				end
				if (en_s3 && !poll_en_new) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	assign any_requested = any_res_q;
	assign granted       = grant_res_q;
	assign enabled_count = count_res_q;

endmodule
`default_nettype wire
